/* rtl/hrs_pkg.sv */
package hrs_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [3:0] LEN_CL    = 4'd14;
   localparam logic [3:0] LEN_CONN  = 4'd10;
   localparam logic [3:0] LEN_KEEP  = 4'd10;
   localparam logic [2:0] LEN_CLOSE = 3'd5;
   localparam logic [3:0] NAME_IDX_MAX = 4'd15;

   localparam logic [31:0] MAG_CAP = 32'h8000_0000;
   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

   localparam logic [8*14-1:0] TXT_CL    = "content-length";
   localparam logic [8*10-1:0] TXT_CONN  = "connection";
   localparam logic [8*10-1:0] TXT_KEEP  = "keep-alive";
   localparam logic [8*5-1:0]  TXT_CLOSE = "close";

   typedef enum logic [1:0] {
      CLASS_HEADER,
      CLASS_HDR_END,
      CLASS_BODY,
      CLASS_BEYOND
   } byte_class_type;

   typedef enum logic [1:0] {
      PART_NAME,
      PART_VALUE,
      PART_ZERO_END,
      PART_IGNORED
   } line_part_type;

   typedef enum logic [1:0] {
      NUM_BLANKS,
      NUM_SIGNED,
      NUM_DIGITS,
      NUM_STOPPED
   } num_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic [7:0] lower;
      logic       is_cr;
      logic       is_lf;
      logic       is_zero;
      logic       is_colon;
      logic       is_blank;
      logic       is_plus;
      logic       is_minus;
      logic       is_digit;
      logic [3:0] digit;
   } item_type;

   function automatic logic [7:0] cl_char(input logic [3:0] idx);
      logic [7:0] c;
      c = 8'h00;
      if (idx < LEN_CL) begin
         c = TXT_CL[8*(13 - int'(idx)) +: 8];
      end
      return c;
   endfunction

   function automatic logic [7:0] conn_char(input logic [3:0] idx);
      logic [7:0] c;
      c = 8'h00;
      if (idx < LEN_CONN) begin
         c = TXT_CONN[8*(9 - int'(idx)) +: 8];
      end
      return c;
   endfunction

   function automatic logic [7:0] keep_char(input logic [3:0] idx);
      logic [7:0] c;
      c = 8'h00;
      if (idx < LEN_KEEP) begin
         c = TXT_KEEP[8*(9 - int'(idx)) +: 8];
      end
      return c;
   endfunction

   function automatic logic [7:0] close_char(input logic [2:0] idx);
      logic [7:0] c;
      c = 8'h00;
      if (idx < LEN_CLOSE) begin
         c = TXT_CLOSE[8*(4 - int'(idx)) +: 8];
      end
      return c;
   endfunction

endpackage

/* rtl/hrs_front.sv */
module hrs_front
   import hrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_value,
   input  logic       queue_full,
   output logic       push_valid,
   output item_type   push_item
);

   logic     front_valid_ff, front_valid_in;
   item_type item_ff, item_in;
   logic     accept;
   logic     advance;

   always_comb begin
      logic [7:0] b;
      b = req_byte_value;
      item_in.data     = b;
      item_in.lower    = (b >= "A" && b <= "Z") ? 8'(b + 8'd32) : b;
      item_in.is_cr    = (b == 8'h0D);
      item_in.is_lf    = (b == 8'h0A);
      item_in.is_zero  = (b == 8'h00);
      item_in.is_colon = (b == ":");
      item_in.is_blank = (b == " ") || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C);
      item_in.is_plus  = (b == "+");
      item_in.is_minus = (b == "-");
      item_in.is_digit = (b >= "0") && (b <= "9");
      item_in.digit    = 4'(b - "0");
   end

   assign advance   = front_valid_ff && !queue_full;
   assign req_ready = !front_valid_ff || !queue_full;
   assign accept    = req_valid && req_ready;

   assign push_valid = advance;
   assign push_item  = item_ff;

   always_comb begin
      front_valid_in = front_valid_ff;
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (advance) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

/* rtl/hrs_queue.sv */
module hrs_queue
   import hrs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     pop_valid,
   output item_type pop_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type             store [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push_valid && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push_valid) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         store[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/hrs_back.sv */
module hrs_back
   import hrs_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  item_type    item,
   output logic        item_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_byte,
   output logic [1:0]  rsp_byte_class,
   output logic        rsp_header_end,
   output logic        rsp_body_last,
   output logic signed [31:0] rsp_declared_length,
   output logic        rsp_keep_alive_seen,
   output logic        rsp_close_seen,
   output logic        rsp_persistent,
   output logic [31:0] rsp_header_bytes,
   output logic [31:0] rsp_body_bytes
);

   localparam int CW    = COUNT_WIDTH;
   localparam int CMP_W = (CW > 31) ? CW : 31;

   // Scanner state.
   logic          in_body_ff, in_body_in;
   logic [1:0]    lf_run_ff, lf_run_in;
   line_part_type part_ff, part_in;
   logic          nonempty_ff, nonempty_in;
   logic [3:0]    name_idx_ff, name_idx_in;
   logic [1:0]    miss_ff, miss_in;
   num_phase_type phase_ff, phase_in;
   logic          neg_ff, neg_in;
   logic [31:0]   accum_ff, accum_in;
   logic [3:0]    keep_pos_ff, keep_pos_in;
   logic [2:0]    close_pos_ff, close_pos_in;
   logic [1:0]    match_ff, match_in;
   logic [31:0]   length_ff, length_in;
   logic          keep_flag_ff, keep_flag_in;
   logic          close_flag_ff, close_flag_in;
   logic [CW-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic [CW-1:0] body_cnt_ff, body_cnt_in;

   // Result register.
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     o_data_ff;
   byte_class_type o_class_ff, o_class_in;
   logic           o_hend_ff, o_hend_in;
   logic           o_last_ff, o_last_in;
   logic [31:0]    o_length_ff;
   logic           o_keep_ff, o_close_ff, o_pers_ff;
   logic [31:0]    o_hdr_ff, o_hdr_in;
   logic [31:0]    o_body_ff, o_body_in;

   logic [31:0]   num_value;
   logic [35:0]   accum_next;
   logic [31:0]   accum_digit;
   logic [CW-1:0] body_inc;

   assign item_pop = item_valid && (!rsp_valid_ff || rsp_ready);

   // Value that a finished content-length line would store, saturated as strtol does.
   always_comb begin
      if (neg_ff) begin
         num_value = (accum_ff >= MAG_CAP) ? MAG_CAP : 32'(~accum_ff + 32'd1);
      end else begin
         num_value = (accum_ff > POS_MAX) ? POS_MAX : accum_ff;
      end
      accum_next  = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0} + {32'd0, item.digit};
      accum_digit = (accum_next > {4'd0, MAG_CAP}) ? MAG_CAP : accum_next[31:0];
      body_inc    = (body_cnt_ff != '1) ? CW'(body_cnt_ff + 1'b1) : body_cnt_ff;
   end

   always_comb begin
      in_body_in    = in_body_ff;
      lf_run_in     = lf_run_ff;
      part_in       = part_ff;
      nonempty_in   = nonempty_ff;
      name_idx_in   = name_idx_ff;
      miss_in       = miss_ff;
      phase_in      = phase_ff;
      neg_in        = neg_ff;
      accum_in      = accum_ff;
      keep_pos_in   = keep_pos_ff;
      close_pos_in  = close_pos_ff;
      match_in      = match_ff;
      length_in     = length_ff;
      keep_flag_in  = keep_flag_ff;
      close_flag_in = close_flag_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      body_cnt_in   = body_cnt_ff;
      o_class_in    = CLASS_HEADER;
      o_hend_in     = 1'b0;
      o_last_in     = 1'b0;

      if (!in_body_ff) begin
         hdr_cnt_in = (hdr_cnt_ff != '1) ? CW'(hdr_cnt_ff + 1'b1) : hdr_cnt_ff;
         if (item.is_cr || item.is_lf) begin
            if (nonempty_ff) begin
               if (part_ff == PART_VALUE || part_ff == PART_ZERO_END) begin
                  if (match_ff[0]) begin
                     length_in = num_value;
                  end else if (match_ff[1]) begin
                     if (keep_pos_ff == LEN_KEEP) begin
                        keep_flag_in = 1'b1;
                     end else if (close_pos_ff == LEN_CLOSE) begin
                        close_flag_in = 1'b1;
                     end
                  end
               end
               part_in      = PART_NAME;
               nonempty_in  = 1'b0;
               name_idx_in  = '0;
               miss_in      = '0;
               phase_in     = NUM_BLANKS;
               neg_in       = 1'b0;
               accum_in     = '0;
               keep_pos_in  = '0;
               close_pos_in = '0;
               match_in     = '0;
            end
            if (item.is_lf) begin
               lf_run_in = 2'(lf_run_ff + 1'b1);
               // A second LF with only CRs since the first closes the header.
               if (lf_run_ff != 2'd0) begin
                  in_body_in = 1'b1;
                  o_hend_in  = 1'b1;
                  o_class_in = CLASS_HDR_END;
                  o_last_in  = (length_in == '0);
               end
            end
         end else begin
            lf_run_in   = '0;
            nonempty_in = 1'b1;
            unique case (part_ff)
               PART_NAME: begin
                  if (item.is_zero) begin
                     part_in = PART_IGNORED;
                  end else if (item.is_colon) begin
                     part_in = PART_VALUE;
                     if (!miss_ff[0] && name_idx_ff == LEN_CL) begin
                        match_in = 2'b01;
                     end else if (!miss_ff[1] && name_idx_ff == LEN_CONN) begin
                        match_in = 2'b10;
                     end else begin
                        match_in = 2'b00;
                     end
                  end else begin
                     if (name_idx_ff >= LEN_CL || item.lower != cl_char(name_idx_ff)) begin
                        miss_in[0] = 1'b1;
                     end
                     if (name_idx_ff >= LEN_CONN || item.lower != conn_char(name_idx_ff)) begin
                        miss_in[1] = 1'b1;
                     end
                     if (name_idx_ff < NAME_IDX_MAX) begin
                        name_idx_in = 4'(name_idx_ff + 1'b1);
                     end
                  end
               end
               PART_VALUE: begin
                  if (item.is_zero) begin
                     part_in = PART_ZERO_END;
                  end else begin
                     unique case (phase_ff)
                        NUM_BLANKS: begin
                           if (item.is_blank) begin
                              phase_in = NUM_BLANKS;
                           end else if (item.is_plus) begin
                              phase_in = NUM_SIGNED;
                           end else if (item.is_minus) begin
                              neg_in   = 1'b1;
                              phase_in = NUM_SIGNED;
                           end else if (item.is_digit) begin
                              accum_in = {28'd0, item.digit};
                              phase_in = NUM_DIGITS;
                           end else begin
                              phase_in = NUM_STOPPED;
                           end
                        end
                        NUM_SIGNED: begin
                           if (item.is_digit) begin
                              accum_in = {28'd0, item.digit};
                              phase_in = NUM_DIGITS;
                           end else begin
                              phase_in = NUM_STOPPED;
                           end
                        end
                        NUM_DIGITS: begin
                           if (item.is_digit) begin
                              accum_in = accum_digit;
                           end else begin
                              phase_in = NUM_STOPPED;
                           end
                        end
                        NUM_STOPPED: begin
                           phase_in = NUM_STOPPED;
                        end
                     endcase
                     if (keep_pos_ff < LEN_KEEP) begin
                        if (item.lower == keep_char(keep_pos_ff)) begin
                           keep_pos_in = 4'(keep_pos_ff + 1'b1);
                        end else begin
                           keep_pos_in = (item.lower == keep_char(4'd0)) ? 4'd1 : 4'd0;
                        end
                     end
                     if (close_pos_ff < LEN_CLOSE) begin
                        if (item.lower == close_char(close_pos_ff)) begin
                           close_pos_in = 3'(close_pos_ff + 1'b1);
                        end else begin
                           close_pos_in = (item.lower == close_char(3'd0)) ? 3'd1 : 3'd0;
                        end
                     end
                  end
               end
               PART_ZERO_END, PART_IGNORED: begin
                  part_in = part_ff;
               end
            endcase
         end
      end else begin
         // A negative length means the body has no limit.
         if (!length_ff[31] && (CMP_W'(body_cnt_ff) >= CMP_W'(length_ff[30:0]))) begin
            o_class_in = CLASS_BEYOND;
         end else begin
            o_class_in  = CLASS_BODY;
            body_cnt_in = body_inc;
            o_last_in   = !length_ff[31] && (CMP_W'(body_inc) == CMP_W'(length_ff[30:0]));
         end
      end

      o_hdr_in  = ((hdr_cnt_in >> 32) != '0) ? '1 : 32'(hdr_cnt_in);
      o_body_in = ((body_cnt_in >> 32) != '0) ? '1 : 32'(body_cnt_in);

      rsp_valid_in = rsp_valid_ff;
      if (item_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff    <= 1'b0;
         lf_run_ff     <= '0;
         part_ff       <= PART_NAME;
         nonempty_ff   <= 1'b0;
         name_idx_ff   <= '0;
         miss_ff       <= '0;
         phase_ff      <= NUM_BLANKS;
         neg_ff        <= 1'b0;
         accum_ff      <= '0;
         keep_pos_ff   <= '0;
         close_pos_ff  <= '0;
         match_ff      <= '0;
         length_ff     <= '1;
         keep_flag_ff  <= 1'b0;
         close_flag_ff <= 1'b0;
         hdr_cnt_ff    <= '0;
         body_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_pop) begin
            in_body_ff    <= in_body_in;
            lf_run_ff     <= lf_run_in;
            part_ff       <= part_in;
            nonempty_ff   <= nonempty_in;
            name_idx_ff   <= name_idx_in;
            miss_ff       <= miss_in;
            phase_ff      <= phase_in;
            neg_ff        <= neg_in;
            accum_ff      <= accum_in;
            keep_pos_ff   <= keep_pos_in;
            close_pos_ff  <= close_pos_in;
            match_ff      <= match_in;
            length_ff     <= length_in;
            keep_flag_ff  <= keep_flag_in;
            close_flag_ff <= close_flag_in;
            hdr_cnt_ff    <= hdr_cnt_in;
            body_cnt_ff   <= body_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         o_data_ff   <= item.data;
         o_class_ff  <= o_class_in;
         o_hend_ff   <= o_hend_in;
         o_last_ff   <= o_last_in;
         o_length_ff <= length_in;
         o_keep_ff   <= keep_flag_in;
         o_close_ff  <= close_flag_in;
         o_pers_ff   <= in_body_in && keep_flag_in && !close_flag_in;
         o_hdr_ff    <= o_hdr_in;
         o_body_ff   <= o_body_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data_byte       = o_data_ff;
   assign rsp_byte_class      = o_class_ff;
   assign rsp_header_end      = o_hend_ff;
   assign rsp_body_last       = o_last_ff;
   assign rsp_declared_length = o_length_ff;
   assign rsp_keep_alive_seen = o_keep_ff;
   assign rsp_close_seen      = o_close_ff;
   assign rsp_persistent      = o_pers_ff;
   assign rsp_header_bytes    = o_hdr_ff;
   assign rsp_body_bytes      = o_body_ff;

endmodule

/* rtl/http_response_header_scanner_unit.sv */
// HTTP response header scanner.
// The req_ channel carries one response byte per request; the rsp_ channel
// returns one result per byte: the byte itself, its class (header, header-ending
// LF, body, beyond the declared length), the header and body-complete marks, the
// parsed content-length, the connection flags and the saturating byte counts.
// A request is accepted into a classifying register, passes through a two-entry
// queue and is scanned by the back end, whose result register drives rsp_.
// A request passes the front register, the queue and the result register before
// rsp_valid rises; one byte is taken every cycle while rsp_ready is held high.
// When the receiver holds rsp_ready low, the result register keeps its request,
// the queue and the front register fill, and req_ready falls once four
// requests are held: one in the result register, two in the queue and one in
// the front register. Reset clears all scanning state: header phase, no
// connection flags, zero counts and a declared length of -1; no result is
// valid after reset.
module http_response_header_scanner_unit
   import hrs_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_byte,
   output logic [1:0]  rsp_byte_class,
   output logic        rsp_header_end,
   output logic        rsp_body_last,
   output logic signed [31:0] rsp_declared_length,
   output logic        rsp_keep_alive_seen,
   output logic        rsp_close_seen,
   output logic        rsp_persistent,
   output logic [31:0] rsp_header_bytes,
   output logic [31:0] rsp_body_bytes
);

   logic     push_valid;
   item_type push_item;
   logic     queue_full;
   logic     pop;
   logic     pop_valid;
   item_type pop_item;

   hrs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_value (req_byte_value),
      .queue_full     (queue_full),
      .push_valid     (push_valid),
      .push_item      (push_item)
   );

   hrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   hrs_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (pop_valid),
      .item                (pop_item),
      .item_pop            (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_byte_class      (rsp_byte_class),
      .rsp_header_end      (rsp_header_end),
      .rsp_body_last       (rsp_body_last),
      .rsp_declared_length (rsp_declared_length),
      .rsp_keep_alive_seen (rsp_keep_alive_seen),
      .rsp_close_seen      (rsp_close_seen),
      .rsp_persistent      (rsp_persistent),
      .rsp_header_bytes    (rsp_header_bytes),
      .rsp_body_bytes      (rsp_body_bytes)
   );

   a_hend_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_header_end == (rsp_byte_class == CLASS_HDR_END)))
      else $error("header end mark disagrees with byte class");

   a_persistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_persistent) |-> (rsp_keep_alive_seen && !rsp_close_seen))
      else $error("persistent reported without keep-alive or with close");

   a_beyond: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_byte_class == CLASS_BEYOND)
         |-> (!rsp_body_last && !rsp_declared_length[31]))
      else $error("beyond-length byte without a non-negative length");

   a_reset_idle: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

/* test/http_response_header_scanner_unit_test.sv */
module http_response_header_scanner_unit_test
   import hrs_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] KIND_LENGTH = 2'b01;
   localparam logic [1:0] KIND_CONN   = 2'b10;
   localparam logic [7:0] CHR_CR = 8'h0D;
   localparam logic [7:0] CHR_LF = 8'h0A;
   localparam logic [7:0] CHR_VT = 8'h0B;
   localparam logic [7:0] CHR_FF = 8'h0C;
   localparam logic [7:0] CHR_TAB = 8'h09;
   localparam logic [7:0] CHR_NUL = 8'h00;

   typedef struct {
      logic [7:0]         data;
      byte_class_type     cls;
      logic               hend;
      logic               last;
      logic signed [31:0] len;
      logic               keep;
      logic               closed;
      logic               pers;
      logic [31:0]        hbytes;
      logic [31:0]        bbytes;
   } scan_result_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_byte_value = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_data_byte;
   logic [1:0] rsp_byte_class;
   logic rsp_header_end;
   logic rsp_body_last;
   logic signed [31:0] rsp_declared_length;
   logic rsp_keep_alive_seen;
   logic rsp_close_seen;
   logic rsp_persistent;
   logic [31:0] rsp_header_bytes;
   logic [31:0] rsp_body_bytes;

   http_response_header_scanner_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_byte_value(req_byte_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data_byte(rsp_data_byte),
      .rsp_byte_class(rsp_byte_class),
      .rsp_header_end(rsp_header_end),
      .rsp_body_last(rsp_body_last),
      .rsp_declared_length(rsp_declared_length),
      .rsp_keep_alive_seen(rsp_keep_alive_seen),
      .rsp_close_seen(rsp_close_seen),
      .rsp_persistent(rsp_persistent),
      .rsp_header_bytes(rsp_header_bytes),
      .rsp_body_bytes(rsp_body_bytes)
   );

   // Scanner state mirrored from the block.
   string kw_length = "content-length";
   string kw_conn   = "connection";
   string kw_keep   = "keep-alive";
   string kw_close  = "close";

   logic          body_phase = 1'b0;
   logic [1:0]    lf_count = '0;
   line_part_type part = PART_NAME;
   logic          line_has_data = 1'b0;
   logic [3:0]    name_pos = '0;
   logic [1:0]    name_miss = '0;
   num_phase_type num_phase = NUM_BLANKS;
   logic          num_neg = 1'b0;
   logic [31:0]   num_mag = '0;
   logic [3:0]    keep_pos = '0;
   logic [2:0]    close_pos = '0;
   logic [1:0]    line_kind = '0;
   logic signed [31:0] content_len = -32'sd1;
   logic          keep_found = 1'b0;
   logic          close_req = 1'b0;
   logic [31:0]   hdr_count = '0;
   logic [31:0]   body_count = '0;

   scan_result_type expected_q[$];
   logic [7:0]   line_q[$];
   int failures = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit steady = 0;
   bit close_lines_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
   endfunction

   function automatic logic signed [31:0] parsed_length();
      if (num_neg) begin
         if (num_mag >= MAG_CAP) return 32'sh8000_0000;
         return -$signed(num_mag);
      end
      if (num_mag > POS_MAX) return 32'sh7FFF_FFFF;
      return $signed(num_mag);
   endfunction

   task automatic clear_line();
      part = PART_NAME;
      line_has_data = 1'b0;
      name_pos = '0;
      name_miss = '0;
      num_phase = NUM_BLANKS;
      num_neg = 1'b0;
      num_mag = '0;
      keep_pos = '0;
      close_pos = '0;
      line_kind = '0;
   endtask

   task automatic close_line();
      if (part == PART_VALUE || part == PART_ZERO_END) begin
         if (line_kind & KIND_LENGTH) begin
            content_len = parsed_length();
         end else if (line_kind & KIND_CONN) begin
            if (keep_pos == LEN_KEEP) keep_found = 1'b1;
            else if (close_pos == LEN_CLOSE) close_req = 1'b1;
         end
      end
      clear_line();
   endtask

   task automatic scan_name_byte(input logic [7:0] b);
      logic [7:0] lc;
      lc = to_lower(b);
      if (b == CHR_NUL) begin
         part = PART_IGNORED;
      end else if (b == ":") begin
         part = PART_VALUE;
         line_kind = '0;
         if (!name_miss[0] && name_pos == LEN_CL) line_kind = KIND_LENGTH;
         else if (!name_miss[1] && name_pos == LEN_CONN) line_kind = KIND_CONN;
      end else begin
         if (name_pos >= LEN_CL || lc != kw_length[name_pos]) name_miss[0] = 1'b1;
         if (name_pos >= LEN_CONN || lc != kw_conn[name_pos]) name_miss[1] = 1'b1;
         if (name_pos < NAME_IDX_MAX) name_pos++;
      end
   endtask

   task automatic scan_value_byte(input logic [7:0] b);
      logic [7:0] lc;
      logic       digit;
      logic [63:0] m;
      lc = to_lower(b);
      digit = (b >= "0" && b <= "9");
      if (b == CHR_NUL) begin
         part = PART_ZERO_END;
         return;
      end
      case (num_phase)
         NUM_BLANKS: begin
            if (b == " " || b == CHR_TAB || b == CHR_VT || b == CHR_FF) begin
            end else if (b == "+") begin
               num_phase = NUM_SIGNED;
            end else if (b == "-") begin
               num_neg = 1'b1;
               num_phase = NUM_SIGNED;
            end else if (digit) begin
               num_mag = 32'(b - 8'd48);
               num_phase = NUM_DIGITS;
            end else begin
               num_phase = NUM_STOPPED;
            end
         end
         NUM_SIGNED: begin
            if (digit) begin
               num_mag = 32'(b - 8'd48);
               num_phase = NUM_DIGITS;
            end else begin
               num_phase = NUM_STOPPED;
            end
         end
         NUM_DIGITS: begin
            if (digit) begin
               m = 64'(num_mag) * 64'd10 + 64'(b - 8'd48);
               num_mag = (m > 64'(MAG_CAP)) ? MAG_CAP : m[31:0];
            end else begin
               num_phase = NUM_STOPPED;
            end
         end
         default: begin
         end
      endcase
      if (keep_pos < LEN_KEEP) begin
         if (lc == kw_keep[keep_pos]) keep_pos++;
         else keep_pos = (lc == kw_keep[0]) ? 4'd1 : 4'd0;
      end
      if (close_pos < LEN_CLOSE) begin
         if (lc == kw_close[close_pos]) close_pos++;
         else close_pos = (lc == kw_close[0]) ? 3'd1 : 3'd0;
      end
   endtask

   // Advances the mirrored scanner by one byte and returns what the block should report.
   task automatic scan_response_byte(input logic [7:0] b, output scan_result_type r);
      r.cls = CLASS_HEADER;
      r.hend = 1'b0;
      r.last = 1'b0;
      if (!body_phase) begin
         if (hdr_count != '1) hdr_count++;
         if (b == CHR_CR || b == CHR_LF) begin
            if (line_has_data) close_line();
            if (b == CHR_LF) begin
               lf_count++;
               if (lf_count >= 2) begin
                  body_phase = 1'b1;
                  r.hend = 1'b1;
                  r.cls = CLASS_HDR_END;
                  r.last = (content_len == 0);
               end
            end
         end else begin
            lf_count = '0;
            line_has_data = 1'b1;
            if (part == PART_NAME) scan_name_byte(b);
            else if (part == PART_VALUE) scan_value_byte(b);
         end
      end else begin
         if (content_len >= 0 && body_count >= $unsigned(content_len)) begin
            r.cls = CLASS_BEYOND;
         end else begin
            r.cls = CLASS_BODY;
            if (body_count != '1) body_count++;
            if (content_len >= 0 && body_count == $unsigned(content_len)) r.last = 1'b1;
         end
      end
      r.data = b;
      r.len = content_len;
      r.keep = keep_found;
      r.closed = close_req;
      r.pers = body_phase && keep_found && !close_req;
      r.hbytes = hdr_count;
      r.bbytes = body_count;
   endtask

   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
   endfunction

   // Called just after a rising edge; returns just after the edge that ends the gap.
   task automatic send_byte(input logic [7:0] b);
      scan_result_type r;
      int gap;
      req_valid <= 1'b1;
      req_byte_value <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      scan_response_byte(b, r);
      expected_q.insert(expected_q.size(), r);
      gap = (steady || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic add_byte(input logic [7:0] c);
      line_q.insert(line_q.size(), c);
   endtask

   task automatic push_text(input string s, input bit mixed_case);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (mixed_case && $urandom_range(0, 1) && ((c >= "a" && c <= "z") ||
                                                    (c >= "A" && c <= "Z")))
            c = c ^ 8'h20;
         add_byte(c);
      end
   endtask

   task automatic push_eol(input bit any_ending);
      int k;
      k = any_ending ? $urandom_range(0, 2) : 0;
      if (k != 1) add_byte(CHR_CR);
      if (k != 2) add_byte(CHR_LF);
   endtask

   task automatic send_line(inout int sent);
      while (line_q.size() != 0) begin
         send_byte(line_q.pop_front());
         sent++;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
         failures++;
      end
   endtask

   always @(posedge clock) begin : result_checker
      scan_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $error("result with no request outstanding: byte %0h", rsp_data_byte);
            failures++;
         end else begin
            e = expected_q.pop_front();
            check_field("data_byte", e.data, rsp_data_byte);
            check_field("byte_class", e.cls, rsp_byte_class);
            check_field("header_end", e.hend, rsp_header_end);
            check_field("body_last", e.last, rsp_body_last);
            check_field("declared_length", e.len, rsp_declared_length);
            check_field("keep_alive_seen", e.keep, rsp_keep_alive_seen);
            check_field("close_seen", e.closed, rsp_close_seen);
            check_field("persistent", e.pers, rsp_persistent);
            check_field("header_bytes", e.hbytes, rsp_header_bytes);
            check_field("body_bytes", e.bbytes, rsp_body_bytes);
         end
      end
   end

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (stall_left > 0 && !steady) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 5) == 0) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Status line, length extremes, zero bytes on both sides of the colon and connection values.
   task automatic test_directed_header_lines();
      int sent;
      sent = 0;
      push_text("HTTP/1.0 200 OK", 0); push_eol(0);
      push_text("CONTENT-LENGTH:", 0);
      add_byte(CHR_TAB); add_byte(CHR_VT); add_byte(CHR_FF);
      push_text(" +2147483647", 0); push_eol(0);
      push_text("content-length: 2147483648", 0); add_byte(CHR_LF);
      push_text("Content-Length: -2147483648", 0); add_byte(CHR_CR);
      push_text("content-length: -99999999999x", 0); push_eol(0);
      push_text("Content-length: abc", 0); push_eol(0);
      push_text("content-length:+", 0); push_eol(0);
      push_text("Con", 0); add_byte(CHR_NUL);
      push_text("tent-Length: 5", 0); push_eol(0);
      push_text("content-length: 7", 0); add_byte(CHR_NUL);
      push_text(" 9", 0); push_eol(0);
      push_text("content-lengthx: 3", 0); push_eol(0);
      push_text("Connection: close, Keep-Alive", 0); push_eol(0);
      push_text("connectio: close", 0); push_eol(0);
      push_text("X-Other: keep-alive", 0); push_eol(0);
      push_text("a:b:c", 0); add_byte(8'hFF); push_eol(0);
      send_line(sent);
   endtask

   task automatic build_random_line();
      int r;
      int n;
      logic [7:0] c;
      string nm;
      string tokens[8] = '{"keep-alive", "close", "Keep-Alive, Upgrade", "kkeep-alive",
                           "keep-aliv", "clos", "upgrade", "cclose"};
      r = $urandom_range(0, 99);
      if (r < 25) begin
         n = $urandom_range(0, 9);
         if (n == 0) nm = "content-lengt";
         else if (n == 1) nm = "content-lengthh";
         else nm = "content-length";
         push_text(nm, 1);
         add_byte(":");
         repeat ($urandom_range(0, 2)) begin
            n = $urandom_range(0, 3);
            add_byte(n == 0 ? " " : (n == 1 ? CHR_TAB : (n == 2 ? CHR_VT : CHR_FF)));
         end
         n = $urandom_range(0, 5);
         if (n == 0) add_byte("-");
         else if (n == 1) add_byte("+");
         repeat ($urandom_range(0, 12)) add_byte(8'($urandom_range(48, 57)));
         if ($urandom_range(0, 4) == 0) add_byte(8'($urandom_range(32, 126)));
      end else if (r < 50) begin
         push_text($urandom_range(0, 9) == 0 ? "connectiom" : "connection", 1);
         push_text(": ", 0);
         n = $urandom_range(0, 7);
         if (!close_lines_on && (n == 1 || n == 7)) n = 6;
         push_text(tokens[n], 1);
      end else if (r < 70) begin
         push_text("x-", 0);
         repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(97, 122)));
         add_byte(":");
         repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(32, 126)));
      end else if (r < 85) begin
         repeat ($urandom_range(1, 8)) begin
            do c = 8'($urandom_range(0, 255)); while (c == CHR_CR || c == CHR_LF);
            add_byte(c);
         end
      end else begin
         // A zero byte breaks the line either in the name or in the value.
         if ($urandom_range(0, 1)) begin
            push_text("content", 1); add_byte(CHR_NUL); push_text("-length: 12", 1);
         end else begin
            push_text("content-length: 4", 1); add_byte(CHR_NUL); push_text("2", 0);
         end
      end
      push_eol(1);
   endtask

   task automatic test_random_header_lines(input int budget);
      int sent;
      sent = 0;
      while (sent < budget) begin
         build_random_line();
         send_line(sent);
      end
   endtask

   task automatic test_sender_waits_for_drain();
      int sent;
      sent = 0;
      push_text("Connection: keep-alive", 1); push_eol(0);
      send_line(sent);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_back_to_back(input int budget);
      steady = 1;
      test_random_header_lines(budget);
      steady = 0;
   endtask

   // A last length line leaves a small body, so bytes beyond the length are reached.
   task automatic test_header_end_and_body(input int body_len);
      int sent;
      sent = 0;
      push_text($sformatf("Content-Length: %0d", $urandom_range(0, 30)), 1);
      push_eol(0);
      if ($urandom_range(0, 1)) add_byte(CHR_CR);
      add_byte(CHR_LF);
      send_line(sent);
      repeat (body_len) send_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      close_lines_on = $urandom_range(0, 1);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_header_lines();
      test_random_header_lines(30);
      test_sender_waits_for_drain();
      test_back_to_back(30);
      test_random_header_lines(30);
      test_header_end_and_body(40);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
